FILE: hdl/atc_pkg.sv
// ============================================================================
// Tilt calculator package
// Shared widths, pipeline depths, register codes, constants and helpers.
// ============================================================================
package atc_pkg;

   localparam int G_FRAC_BITS     = 11;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int Q_FRAC_BITS     = 30;

   localparam int NUM_AXES = 3;

   // Calibration divider.
   localparam int DVD_W = 8 + G_FRAC_BITS + 1;
   localparam int DIV_W = 9;

   // Square root unit.
   localparam int SQ_W    = 32;
   localparam int RAD_SH  = 28;
   localparam int RAD_W   = SQ_W + RAD_SH;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int SREM_W  = ROOT_W + 2;
   localparam int MAG_SH  = RAD_SH / 2;

   // Arctangent unit.
   localparam int CORDIC_STEPS = 30;
   localparam int CW           = 40;
   localparam int ZW           = 33;
   localparam int AW           = 35;
   localparam int ROLL_SH      = 20;
   localparam int PITCH_SH     = 14;

   // Pipeline depths.
   localparam int LANE_LAT    = DVD_W + 2;
   localparam int PIPE_LAT    = LANE_LAT + 2 + ROOT_W + 1 + CORDIC_STEPS + 1;
   localparam int G_DLY       = PIPE_LAT - LANE_LAT - 1;
   localparam int G_TAP_PREP  = 2 + ROOT_W - 1;
   localparam int G_TAP_OUT   = G_DLY - 1;
   localparam int M_DLY       = CORDIC_STEPS + 1;

   // Register codes.
   localparam logic [2:0] REG_ZERO_X = 3'd0;
   localparam logic [2:0] REG_ZERO_Y = 3'd1;
   localparam logic [2:0] REG_ZERO_Z = 3'd2;
   localparam logic [2:0] REG_ONE_X  = 3'd3;
   localparam logic [2:0] REG_ONE_Y  = 3'd4;
   localparam logic [2:0] REG_ONE_Z  = 3'd5;

   localparam logic [7:0] ZERO_RESET = 8'd128;
   localparam logic [7:0] ONE_RESET  = 8'd154;

   localparam logic signed [AW-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;

   localparam logic [29:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
      30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
      30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
      30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1
   };

   typedef struct packed {
      logic signed [15:0] gx;
      logic signed [15:0] gy;
      logic signed [15:0] gz;
      logic               err;
   } g_set_type;

   function automatic logic signed [15:0] angle_out(input logic signed [AW-1:0] q);
      logic signed [AW-1:0] t;
      logic signed [AW-1:0] s;
      t = q + (AW'(1) <<< (Q_FRAC_BITS - 1 - ANGLE_FRAC_BITS));
      s = t >>> (Q_FRAC_BITS - ANGLE_FRAC_BITS);
      if (s > AW'(32767)) begin
         return 16'sh7fff;
      end else if (s < -AW'(32768)) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

endpackage

FILE: hdl/accel_tilt_calc.sv
// ============================================================================
// Accelerometer tilt calculator
// Calibrates a 3-axis sample and computes magnitude, roll and pitch.
// ============================================================================
// The block takes one sample request per clock while it is not stalled and
// returns one result per sample. The depth is set by the 20-stage
// calibration divider, the 30-stage square root and the 30-stage arctangent
// that follows it. The whole pipeline advances whenever the output register
// is empty or being read, so a held result stalls every stage behind it.
module accel_tilt_calc import atc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // raw_x, raw_y, raw_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // g_x, g_y, g_z, magnitude, roll_angle, pitch_angle
   output logic        rsp_tuser,   // cal_error
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0] zero_ff [0:NUM_AXES-1];
   logic [7:0] one_ff  [0:NUM_AXES-1];
   logic [2:0] csr_idx;
   logic       csr_wr;

   logic en;
   logic [PIPE_LAT-1:0] vld_ff;

   logic signed [15:0] lane_g   [0:NUM_AXES-1];
   logic               lane_err [0:NUM_AXES-1];
   g_set_type          g_now;
   g_set_type          gdly_ff [0:G_DLY-1];

   logic [SQ_W-2:0] sqx_ff, sqy_ff, sqz_ff;
   logic [SQ_W-1:0] s3_ff, sxz_ff;
   logic [ROOT_W-1:0] mroot, hroot;

   logic [16:0] mag_sum;
   logic [15:0] mag_in;
   logic [15:0] mag_ff [0:M_DLY-1];

   g_set_type            gp;
   logic signed [16:0]   rn, rd;
   logic signed [CW-1:0] rx_ff, ry_ff, px_ff, py_ff;
   logic signed [ZW-1:0] roll_z, pitch_z;

   g_set_type            go;
   logic signed [AW-1:0] roll_base, roll_q, pitch_q;

   logic [95:0] data_ff;
   logic        user_ff;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            zero_ff[i] <= ZERO_RESET;
            one_ff[i]  <= ONE_RESET;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ZERO_X: zero_ff[0] <= csr_pwdata[7:0];
            REG_ZERO_Y: zero_ff[1] <= csr_pwdata[7:0];
            REG_ZERO_Z: zero_ff[2] <= csr_pwdata[7:0];
            REG_ONE_X:  one_ff[0]  <= csr_pwdata[7:0];
            REG_ONE_Y:  one_ff[1]  <= csr_pwdata[7:0];
            REG_ONE_Z:  one_ff[2]  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ZERO_X: csr_prdata = {24'd0, zero_ff[0]};
         REG_ZERO_Y: csr_prdata = {24'd0, zero_ff[1]};
         REG_ZERO_Z: csr_prdata = {24'd0, zero_ff[2]};
         REG_ONE_X:  csr_prdata = {24'd0, one_ff[0]};
         REG_ONE_Y:  csr_prdata = {24'd0, one_ff[1]};
         REG_ONE_Z:  csr_prdata = {24'd0, one_ff[2]};
         default:    csr_prdata = '0;
      endcase
   end

   // Pipeline control.
   assign en         = ~vld_ff[PIPE_LAT-1] | rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   // Axis lanes.
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      atc_axis_lane u_lane (
         .clock (clock),
         .en    (en),
         .raw   (req_tdata[8*a +: 8]),
         .zero  (zero_ff[a]),
         .one   (one_ff[a]),
         .g     (lane_g[a]),
         .err   (lane_err[a])
      );
   end

   assign g_now.gx  = lane_g[0];
   assign g_now.gy  = lane_g[1];
   assign g_now.gz  = lane_g[2];
   assign g_now.err = lane_err[0] | lane_err[1] | lane_err[2];

   always_ff @(posedge clock) begin
      if (en) begin
         gdly_ff[0] <= g_now;
         for (int i = 1; i < G_DLY; i++) begin
            gdly_ff[i] <= gdly_ff[i-1];
         end
      end
   end

   // Squares and sums.
   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= (SQ_W - 1)'($unsigned(32'(g_now.gx * g_now.gx)));
         sqy_ff <= (SQ_W - 1)'($unsigned(32'(g_now.gy * g_now.gy)));
         sqz_ff <= (SQ_W - 1)'($unsigned(32'(g_now.gz * g_now.gz)));
         s3_ff  <= SQ_W'(sqx_ff) + SQ_W'(sqy_ff) + SQ_W'(sqz_ff);
         sxz_ff <= SQ_W'(sqx_ff) + SQ_W'(sqz_ff);
      end
   end

   atc_isqrt u_sqrt_mag (
      .clock (clock),
      .en    (en),
      .rad   ({s3_ff, {RAD_SH{1'b0}}}),
      .root  (mroot)
   );

   atc_isqrt u_sqrt_xz (
      .clock (clock),
      .en    (en),
      .rad   ({sxz_ff, {RAD_SH{1'b0}}}),
      .root  (hroot)
   );

   // Magnitude rounding and delay.
   assign mag_sum = {1'b0, mroot[ROOT_W-1 -: 16]} + 17'(mroot[MAG_SH-1]);
   assign mag_in  = mag_sum[16] ? 16'hffff : mag_sum[15:0];

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff[0] <= mag_in;
         for (int i = 1; i < M_DLY; i++) begin
            mag_ff[i] <= mag_ff[i-1];
         end
      end
   end

   // Arctangent operands.
   assign gp = gdly_ff[G_TAP_PREP];
   assign rn = (gp.gz < 0) ? -17'(gp.gx) : 17'(gp.gx);
   assign rd = (gp.gz < 0) ? -17'(gp.gz) : 17'(gp.gz);

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff <= {{(CW - 17 - ROLL_SH){rd[16]}}, rd, {ROLL_SH{1'b0}}};
         ry_ff <= {{(CW - 17 - ROLL_SH){rn[16]}}, rn, {ROLL_SH{1'b0}}};
         px_ff <= $signed({{(CW - ROOT_W){1'b0}}, hroot});
         py_ff <= {{(CW - 16 - PITCH_SH){gp.gy[15]}}, gp.gy, {PITCH_SH{1'b0}}};
      end
   end

   atc_cordic u_atan_roll (
      .clock (clock),
      .en    (en),
      .x_i   (rx_ff),
      .y_i   (ry_ff),
      .z_o   (roll_z)
   );

   atc_cordic u_atan_pitch (
      .clock (clock),
      .en    (en),
      .x_i   (px_ff),
      .y_i   (py_ff),
      .z_o   (pitch_z)
   );

   // Quadrant fix-up and output register.
   assign go = gdly_ff[G_TAP_OUT];

   always_comb begin
      if (go.gz == 16'sd0) begin
         if (go.gx > 0) begin
            roll_base = HALF_PI_Q30;
         end else if (go.gx < 0) begin
            roll_base = -HALF_PI_Q30;
         end else begin
            roll_base = '0;
         end
      end else begin
         roll_base = AW'(roll_z);
      end
      if (go.gz <= 0) begin
         roll_q = roll_base + ((go.gx > 0) ? PI_Q30 : -PI_Q30);
      end else begin
         roll_q = roll_base;
      end
      if (go.gz != 16'sd0) begin
         pitch_q = AW'(pitch_z);
      end else if (go.gx != 16'sd0) begin
         pitch_q = '0;
      end else if (go.gy > 0) begin
         pitch_q = -HALF_PI_Q30;
      end else if (go.gy < 0) begin
         pitch_q = HALF_PI_Q30;
      end else begin
         pitch_q = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= {angle_out(pitch_q), angle_out(roll_q), mag_ff[M_DLY-1],
                     go.gz, go.gy, go.gx};
         user_ff <= go.err;
      end
   end

   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;

endmodule

FILE: hdl/atc_axis_lane.sv
// ============================================================================
// Axis calibration lane
// Computes (raw - zero) / (one - zero) in Q5.11 with a pipelined restoring
// divider, rounding halves away from zero and saturating to 16 bits.
// ============================================================================
module atc_axis_lane import atc_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [7:0]         raw,
   input  logic [7:0]         zero,
   input  logic [7:0]         one,
   output logic signed [15:0] g,
   output logic               err
);

   logic signed [8:0] diff;
   logic signed [8:0] span;
   logic signed [8:0] adiff;
   logic signed [8:0] aspan;

   logic [DVD_W-1:0] dvd_ff [0:DVD_W];
   logic [DIV_W-1:0] rem_ff [0:DVD_W];
   logic [DVD_W-1:0] quo_ff [0:DVD_W];
   logic [DIV_W-1:0] div_ff [0:DVD_W];
   logic             neg_ff [0:DVD_W];
   logic             err_ff [0:DVD_W];

   logic signed [15:0] g_ff;
   logic signed [15:0] g_in;
   logic               gerr_ff;

   assign diff  = $signed({1'b0, raw}) - $signed({1'b0, zero});
   assign span  = $signed({1'b0, one}) - $signed({1'b0, zero});
   assign adiff = diff[8] ? -diff : diff;
   assign aspan = span[8] ? -span : span;

   always_ff @(posedge clock) begin
      if (en) begin
         dvd_ff[0] <= {adiff[7:0], {(G_FRAC_BITS + 1){1'b0}}} + DVD_W'(aspan[7:0]);
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
         div_ff[0] <= {aspan[7:0], 1'b0};
         neg_ff[0] <= diff[8] ^ span[8];
         err_ff[0] <= (span == 9'sd0);
      end
   end

   for (genvar k = 0; k < DVD_W; k++) begin : g_div
      logic [DIV_W:0] r;
      logic [DIV_W:0] d;
      logic           ge;
      assign r  = {rem_ff[k], dvd_ff[k][DVD_W-1]};
      assign d  = r - {1'b0, div_ff[k]};
      assign ge = (r >= {1'b0, div_ff[k]});
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? d[DIV_W-1:0] : r[DIV_W-1:0];
            dvd_ff[k+1] <= {dvd_ff[k][DVD_W-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][DVD_W-2:0], ge};
            div_ff[k+1] <= div_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            err_ff[k+1] <= err_ff[k];
         end
      end
   end

   always_comb begin
      if (err_ff[DVD_W]) begin
         g_in = '0;
      end else if (neg_ff[DVD_W]) begin
         if (quo_ff[DVD_W] > DVD_W'(32768)) begin
            g_in = 16'sh8000;
         end else begin
            g_in = -$signed(quo_ff[DVD_W][15:0]);
         end
      end else if (quo_ff[DVD_W] > DVD_W'(32767)) begin
         g_in = 16'sh7fff;
      end else begin
         g_in = quo_ff[DVD_W][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff    <= g_in;
         gerr_ff <= err_ff[DVD_W];
      end
   end

   assign g   = g_ff;
   assign err = gerr_ff;

endmodule

FILE: hdl/atc_isqrt.sv
// ============================================================================
// Pipelined integer square root
// Digit-by-digit square root, one result bit per stage, floor result.
// ============================================================================
module atc_isqrt import atc_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  rad,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rad_ff  [0:ROOT_W];
   logic [SREM_W-3:0] rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W];

   assign rad_ff[0]  = rad;
   assign rem_ff[0]  = '0;
   assign root_ff[0] = '0;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [SREM_W-1:0] rs;
      logic [SREM_W-1:0] trial;
      logic [SREM_W-1:0] d;
      logic              ge;
      assign rs    = {rem_ff[k], rad_ff[k][RAD_W-1 -: 2]};
      assign trial = {root_ff[k], 2'b01};
      assign d     = rs - trial;
      assign ge    = (rs >= trial);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? d[SREM_W-3:0] : rs[SREM_W-3:0];
            root_ff[k+1] <= {root_ff[k][ROOT_W-2:0], ge};
            rad_ff[k+1]  <= {rad_ff[k][RAD_W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[ROOT_W];

endmodule

FILE: hdl/atc_cordic.sv
// ============================================================================
// Pipelined arctangent
// Vectoring shift-add rotation, one step per stage, Q30 angle out for x > 0.
// ============================================================================
module atc_cordic import atc_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW-1:0] x_i,
   input  logic signed [CW-1:0] y_i,
   output logic signed [ZW-1:0] z_o
);

   logic signed [CW-1:0] x_s  [0:CORDIC_STEPS];
   logic signed [CW-1:0] y_s  [0:CORDIC_STEPS];
   logic signed [ZW-1:0] z_s  [0:CORDIC_STEPS];
   logic                 zr_s [0:CORDIC_STEPS];

   assign x_s[0]  = x_i;
   assign y_s[0]  = y_i;
   assign z_s[0]  = '0;
   assign zr_s[0] = (y_i == '0);

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] a;
      logic                 pos;
      assign dx  = x_s[k] >>> k;
      assign dy  = y_s[k] >>> k;
      assign a   = $signed({{(ZW - 30){1'b0}}, ATAN_TAB[k]});
      assign pos = (y_s[k] > 0);
      always_ff @(posedge clock) begin
         if (en) begin
            x_s[k+1]  <= pos ? x_s[k] + dy : x_s[k] - dy;
            y_s[k+1]  <= pos ? y_s[k] - dx : y_s[k] + dx;
            z_s[k+1]  <= pos ? z_s[k] + a : z_s[k] - a;
            zr_s[k+1] <= zr_s[k];
         end
      end
   end

   assign z_o = zr_s[CORDIC_STEPS] ? '0 : z_s[CORDIC_STEPS];

endmodule

FILE: hdl/atc_checker.sv
// ============================================================================
// Tilt calculator port checker
// Watches the ports of the tilt calculator over time.
// ============================================================================
module atc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A held result keeps its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("held result changed");

   // Requests are taken exactly when the output stage can move.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow the output stage");

   // No result right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown after reset");

   // A zero magnitude only comes from an all-zero vector.
   a_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[63:48] == 16'd0) |-> (rsp_tdata[47:0] == 48'd0))
      else $error("zero magnitude with nonzero axes");

endmodule

bind accel_tilt_calc atc_checker u_atc_checker (.*);

FILE: dv/tilt_checker.sv
// ----------------------------------------------------------------------------
// Tilt calculator result checker
// Watches the request and result streams, computes the expected calibrated
// axes, magnitude, roll and pitch for each accepted request, and compares
// every accepted result with the oldest pending expectation.
// ----------------------------------------------------------------------------
module tilt_checker import atc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] gx, gy, gz, mag, roll, pitch;
      logic        err;
   } tilt_result_type;

   logic [7:0] zero_cal [3];
   logic [7:0] one_cal [3];
   tilt_result_type tilt_q [$];

   localparam longint ATAN_Q30 [30] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15,
      7, 3, 1};
   localparam longint PI_FIX = 64'sd3373259426;
   localparam longint HALF_PI_FIX = 64'sd1686629713;

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint calibrate(logic [7:0] raw, logic [7:0] z, logic [7:0] o,
                                        inout logic err);
      longint num, span, an, as_, q;
      logic neg;
      num = (longint'(raw) - longint'(z)) * 2048;
      span = longint'(o) - longint'(z);
      if (span == 0) begin
         err = 1'b1;
         return 0;
      end
      neg = (num < 0) != (span < 0);
      an = num < 0 ? -num : num;
      as_ = span < 0 ? -span : span;
      q = (2 * an + as_) / (2 * as_);
      return clamp16(neg ? -q : q);
   endfunction

   function automatic longint vector_atan(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (y == 0) return 0;
      for (int i = 0; i < 30; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y > 0) begin
            x += dy; y -= dx; z += ATAN_Q30[i];
         end else begin
            x -= dy; y += dx; z -= ATAN_Q30[i];
         end
      end
      return z;
   endfunction

   function automatic logic [15:0] angle_q13(longint q30);
      return 16'(clamp16((q30 + (64'sd1 <<< 16)) >>> 17));
   endfunction

   function automatic tilt_result_type predict_tilt(logic [23:0] raw);
      tilt_result_type r;
      logic err;
      longint gx, gy, gz, roll, pitch, n, d;
      longint unsigned sum, mag, h;
      err = 1'b0;
      gx = calibrate(raw[7:0], zero_cal[0], one_cal[0], err);
      gy = calibrate(raw[15:8], zero_cal[1], one_cal[1], err);
      gz = calibrate(raw[23:16], zero_cal[2], one_cal[2], err);
      sum = gx * gx + gy * gy + gz * gz;
      mag = int_sqrt(sum);
      if (sum - mag * mag > mag) mag++;
      if (mag > 65535) mag = 65535;
      if (gz == 0) begin
         roll = gx > 0 ? HALF_PI_FIX : (gx < 0 ? -HALF_PI_FIX : 0);
      end else begin
         n = gx; d = gz;
         if (d < 0) begin
            n = -n; d = -d;
         end
         roll = vector_atan(n * (64'sd1 <<< 20), d * (64'sd1 <<< 20));
      end
      if (gz <= 0) roll += gx > 0 ? PI_FIX : -PI_FIX;
      if (gz != 0) begin
         h = int_sqrt(longint'(gx * gx + gz * gz) << 28);
         pitch = vector_atan(gy * (64'sd1 <<< 14), longint'(h));
      end else if (gx != 0) begin
         pitch = 0;
      end else begin
         pitch = gy > 0 ? -HALF_PI_FIX : (gy < 0 ? HALF_PI_FIX : 0);
      end
      r.gx = 16'(gx); r.gy = 16'(gy); r.gz = 16'(gz);
      r.mag = 16'(mag);
      r.roll = angle_q13(roll);
      r.pitch = angle_q13(pitch);
      r.err = err;
      return r;
   endfunction

   task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      tilt_result_type e;
      if (reset) begin
         zero_cal = '{ZERO_RESET, ZERO_RESET, ZERO_RESET};
         one_cal = '{ONE_RESET, ONE_RESET, ONE_RESET};
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_ZERO_X: zero_cal[0] = csr_pwdata[7:0];
               REG_ZERO_Y: zero_cal[1] = csr_pwdata[7:0];
               REG_ZERO_Z: zero_cal[2] = csr_pwdata[7:0];
               REG_ONE_X:  one_cal[0] = csr_pwdata[7:0];
               REG_ONE_Y:  one_cal[1] = csr_pwdata[7:0];
               REG_ONE_Z:  one_cal[2] = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (tilt_q.size() == 0) begin
               $error("Result arrived with no request pending.");
               fail_count++;
            end else begin
               e = tilt_q.pop_front();
               compare_field("g_x", e.gx, rsp_tdata[15:0]);
               compare_field("g_y", e.gy, rsp_tdata[31:16]);
               compare_field("g_z", e.gz, rsp_tdata[47:32]);
               compare_field("magnitude", e.mag, rsp_tdata[63:48]);
               compare_field("roll_angle", e.roll, rsp_tdata[79:64]);
               compare_field("pitch_angle", e.pitch, rsp_tdata[95:80]);
               compare_field("cal_error", 16'(e.err), 16'(rsp_tuser));
            end
         end
         if (req_tvalid && req_tready) tilt_q.push_back(predict_tilt(req_tdata));
      end
      pending = tilt_q.size();
   end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Tilt calculator testbench
// Drives directed and random sample requests through several calibration
// settings with random gaps on both streams; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb import atc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;
   int          fail_count, pending;
   int          cycle_count;

   accel_tilt_calc dut (.*);

   tilt_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (rsp_tready && rsp_tvalid) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
               rsp_tready <= 0;
               repeat (gap) @(negedge clock);
               rsp_tready <= 1;
            end
         end else if (!rsp_tready) begin
            rsp_tready <= 1;
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {8'($urandom_range(0, 255)), 16'h0, val};
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic send_sample(logic [23:0] d, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic set_calibration(logic [7:0] zx, zy, zz, ox, oy, oz);
      drain_results();
      csr_write(REG_ZERO_X, zx); csr_write(REG_ZERO_Y, zy); csr_write(REG_ZERO_Z, zz);
      csr_write(REG_ONE_X, ox);  csr_write(REG_ONE_Y, oy);  csr_write(REG_ONE_Z, oz);
   endtask

   function automatic logic [23:0] sample_near(logic [7:0] cz);
      logic [7:0] b [3];
      for (int i = 0; i < 3; i++)
         b[i] = ($urandom_range(0, 3) == 0) ? 8'(cz + $urandom_range(0, 2) - 1)
                                            : 8'($urandom_range(0, 255));
      return {b[2], b[1], b[0]};
   endfunction

   initial begin
      logic [23:0] directed [$];
      logic [7:0]  z, o;
      req_tvalid = 0; req_tdata = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      reset = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      directed = '{24'h000000, 24'hffffff, 24'h808080, 24'h80809a, 24'h808066,
                   24'h809a80, 24'h806680, 24'h80ff80, 24'h800080, 24'h9a8080,
                   24'h668080, 24'h8080ff, 24'h808000, 24'h809a9a, 24'h9a9a80,
                   24'h8080a0, 24'h80a080, 24'hff00ff, 24'h00ff00, 24'h55aa33};
      foreach (directed[i]) send_sample(directed[i], (i % 2) == 1);
      set_calibration(8'd0, 8'd255, 8'd100, 8'd255, 8'd0, 8'd100);
      send_sample(24'h123456, 0); send_sample(24'h64ff00, 0); send_sample(24'h000000, 0);
      set_calibration(8'd128, 8'd128, 8'd128, 8'd129, 8'd127, 8'd129);
      send_sample(24'hffffff, 0); send_sample(24'h000000, 0); send_sample(24'h808080, 0);

      for (int phase = 0; phase < 9; phase++) begin
         z = 8'($urandom_range(0, 255));
         o = 8'(z + $urandom_range(1, 60));
         case (phase)
            0: set_calibration(8'd128, 8'd128, 8'd128, 8'd154, 8'd154, 8'd154);
            1: set_calibration(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
            2: set_calibration(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1);
            3: set_calibration(z, z, z, o, 8'(z - 20), o);
            default: set_calibration(z, 8'(z + 3), 8'(z - 5), o,
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         for (int n = 0; n < 150; n++) begin
            if (n == 75) drain_results();
            send_sample(($urandom_range(0, 2) == 0) ? 24'($urandom) : sample_near(z),
                        n < 30 || n > 60);
         end
      end

      drain_results();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
